@@ rtl/core/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, constants and the digit encoding table shared by the scan core.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned ScanLen    = 8;
  localparam int unsigned PosWidth   = $clog2(ScanLen);
  localparam int unsigned MagWidth   = 16;
  localparam int unsigned DigitCount = 3;

  // Division by ten: x / 10 == (x * 52429) >> 19 for every x below 43690.
  localparam int unsigned Recip10Width = 17;
  localparam logic [Recip10Width-1:0] Recip10 = 17'd52429;
  localparam int unsigned Recip10Shift = 19;
  localparam int unsigned ProdWidth    = MagWidth + Recip10Width;

  localparam logic [PosWidth-1:0] PosSign     = 3'd4;
  localparam logic [PosWidth-1:0] PosHundreds = 3'd5;
  localparam logic [PosWidth-1:0] PosTens     = 3'd6;
  localparam logic [PosWidth-1:0] PosUnits    = 3'd7;
  localparam logic [PosWidth-1:0] PosLast     = 3'd7;

  localparam logic [7:0] SegBlank = 8'h00;
  localparam logic [7:0] SegMinus = 8'h40;
  localparam logic [7:0] SegPoint = 8'h80;

  // Digits travel down the pipe; digit[2] is the newest remainder.
  typedef struct packed {
    logic                             negative;
    logic [MagWidth-1:0]              quot;
    logic [DigitCount-1:0][3:0]       digit;
  } ssd_stage_t;

  // Common-cathode pattern, bit 0 is segment a.
  function automatic logic [7:0] seg_digit(input logic [3:0] d);
    logic [7:0] pattern;
    case (d)
      4'd0:    pattern = 8'h3f;
      4'd1:    pattern = 8'h06;
      4'd2:    pattern = 8'h5b;
      4'd3:    pattern = 8'h4f;
      4'd4:    pattern = 8'h66;
      4'd5:    pattern = 8'h6d;
      4'd6:    pattern = 8'h7d;
      4'd7:    pattern = 8'h07;
      4'd8:    pattern = 8'h7f;
      4'd9:    pattern = 8'h6f;
      default: pattern = SegBlank;
    endcase
    return pattern;
  endfunction

endpackage

@@ rtl/core/ssd_sign_stage.sv @@
// ----------------------------------------------------------------------------
// ssd_sign_stage
// First pipeline stage: registers the sign and the magnitude of the reading.
// ----------------------------------------------------------------------------
module ssd_sign_stage
  import ssd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       value_valid,
  output logic                       value_stall,
  input  logic signed [MagWidth-1:0] value,
  output logic                       down_valid,
  input  logic                       down_stall,
  output ssd_stage_t                 down_data
);

  logic       ready;
  ssd_stage_t data_next;

  assign ready       = !down_valid || !down_stall;
  assign value_stall = !ready;

  // The magnitude of the most negative reading, 32768, still fits unsigned.
  always_comb begin
    data_next.negative = value[MagWidth-1];
    data_next.quot     = value[MagWidth-1] ? MagWidth'(-value) : MagWidth'(value);
    data_next.digit    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (ready) begin
      down_valid <= value_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && value_valid) begin
      down_data <= data_next;
    end
  end

endmodule

@@ rtl/core/ssd_div10_stage.sv @@
// ----------------------------------------------------------------------------
// ssd_div10_stage
// One decimal digit per stage: divides the running quotient by ten and
// shifts the remainder into the digit list.
// ----------------------------------------------------------------------------
module ssd_div10_stage
  import ssd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_stall,
  input  ssd_stage_t up_data,
  output logic       down_valid,
  input  logic       down_stall,
  output ssd_stage_t down_data
);

  logic                 ready;
  logic [ProdWidth-1:0] prod;
  logic [MagWidth-1:0]  quot;
  logic [MagWidth-1:0]  tenfold;
  logic [MagWidth-1:0]  rem;
  ssd_stage_t           data_next;

  assign ready    = !down_valid || !down_stall;
  assign up_stall = !ready;

  always_comb begin
    prod    = ProdWidth'(up_data.quot) * ProdWidth'(Recip10);
    quot    = MagWidth'(prod >> Recip10Shift);
    tenfold = MagWidth'({quot, 3'b000}) + MagWidth'({quot, 1'b0});
    rem     = up_data.quot - tenfold;
    data_next.negative = up_data.negative;
    data_next.quot     = quot;
    data_next.digit    = {rem[3:0], up_data.digit[DigitCount-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      down_data <= data_next;
    end
  end

endmodule

@@ rtl/core/ssd_scan.sv @@
// ----------------------------------------------------------------------------
// ssd_scan
// Frame serialiser: encodes one reading into eight segment bytes and plays
// them out one beat per cycle while the scan channel is not stalled, positions 0 to 7.
// ----------------------------------------------------------------------------
module ssd_scan
  import ssd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_stall,
  input  ssd_stage_t          up_data,
  output logic                scan_valid,
  input  logic                scan_stall,
  output logic [PosWidth-1:0] position,
  output logic [7:0]          segments,
  output logic                last
);

  logic [ScanLen-1:0][7:0] frame;
  logic [ScanLen-1:0][7:0] frame_next;
  logic [PosWidth-1:0]     count;
  logic                    free;
  logic                    load;

  // A new frame may enter as the final beat of the current one is taken.
  assign free     = !scan_valid || (count == PosLast && !scan_stall);
  assign load     = free && up_valid;
  assign up_stall = !free;

  always_comb begin
    frame_next              = '0;
    frame_next[PosSign]     = up_data.negative ? SegMinus : SegBlank;
    frame_next[PosHundreds] = seg_digit(up_data.digit[2]);
    frame_next[PosTens]     = seg_digit(up_data.digit[1]) | SegPoint;
    frame_next[PosUnits]    = seg_digit(up_data.digit[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
      count      <= '0;
    end else if (load) begin
      scan_valid <= 1'b1;
      count      <= '0;
    end else if (scan_valid && !scan_stall) begin
      if (count == PosLast) begin
        scan_valid <= 1'b0;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= frame_next;
    end
  end

  assign position = count;
  assign segments = frame[count];
  assign last     = (count == PosLast);

endmodule

@@ rtl/core/signed_decimal_seven_segment_scan_core.sv @@
// ----------------------------------------------------------------------------
// signed_decimal_seven_segment_scan_core
// Turns a signed reading in tenths into an eight-position seven-segment scan.
// ----------------------------------------------------------------------------
// Each reading accepted on the value channel produces one frame of eight
// beats on the scan channel, positions 0 to 7 in order, with last set on
// position 7. Positions 0 to 3 are blank, position 4 shows a minus sign for
// negative readings, and positions 5 to 7 show the hundreds, tens (with the
// decimal point) and units of the magnitude; higher digits are dropped. The
// reading passes a sign stage and three divide-by-ten stages, each of which
// registers it in turn before the serialiser loads the frame. The
// serialiser plays out one beat a cycle while the scan channel is not
// stalled, and takes the next reading on the cycle the final beat of the
// previous frame is accepted, so frames can run gap-free.
module signed_decimal_seven_segment_scan_core
  import ssd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       value_valid,
  output logic                       value_stall,
  input  logic signed [MagWidth-1:0] value,
  output logic                       scan_valid,
  input  logic                       scan_stall,
  output logic [PosWidth-1:0]        position,
  output logic [7:0]                 segments,
  output logic                       last
);

  logic       [DigitCount:0] pipe_valid;
  logic       [DigitCount:0] pipe_stall;
  ssd_stage_t [DigitCount:0] pipe_data;

  ssd_sign_stage u_sign (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .down_valid  (pipe_valid[0]),
    .down_stall  (pipe_stall[0]),
    .down_data   (pipe_data[0])
  );

  for (genvar i = 0; i < DigitCount; i++) begin : g_digit
    ssd_div10_stage u_div (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (pipe_valid[i]),
      .up_stall   (pipe_stall[i]),
      .up_data    (pipe_data[i]),
      .down_valid (pipe_valid[i+1]),
      .down_stall (pipe_stall[i+1]),
      .down_data  (pipe_data[i+1])
    );
  end

  ssd_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (pipe_valid[DigitCount]),
    .up_stall   (pipe_stall[DigitCount]),
    .up_data    (pipe_data[DigitCount]),
    .scan_valid (scan_valid),
    .scan_stall (scan_stall),
    .position   (position),
    .segments   (segments),
    .last       (last)
  );

  // A beat taken mid-frame is followed by the next position of that frame.
  a_position_steps: assert property (@(posedge clk) disable iff (rst)
    scan_valid && !scan_stall && !last |=>
      scan_valid && position == $past(position) + 1'b1)
    else $error("scan position did not advance by one");

  // A new frame always starts at position 0.
  a_frame_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    scan_valid && !scan_stall && last |=> !scan_valid || position == '0)
    else $error("frame did not restart at position 0");

  // The leading four positions are always blank.
  a_leading_blank: assert property (@(posedge clk) disable iff (rst)
    scan_valid && position < PosSign |-> segments == SegBlank)
    else $error("leading position not blank");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed decimal seven-segment scan core.
// ----------------------------------------------------------------------------
// Readings are queued by the stimulus process and presented by a clocked
// driver with random gaps. Every accepted reading is expanded by a local
// predictor into its eight scan beats. A clocked monitor stalls the scan
// channel at random and compares each accepted beat, field by field, with
// the oldest predicted beat. A directed set of edge readings comes first,
// then about two hundred random ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ssd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 24;

  typedef struct packed {
    logic [PosWidth-1:0] position;
    logic [7:0]          segments;
    logic                last;
  } scan_beat_t;

  typedef struct {
    logic signed [MagWidth-1:0] reading;
    bit                         drain;
  } reading_item_t;

  // Common-cathode patterns for the digits 0 to 9.
  localparam logic [7:0] DigitSegs [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       value_valid = 1'b0;
  logic                       value_stall;
  logic signed [MagWidth-1:0] value = '0;
  logic                       scan_valid;
  logic                       scan_stall = 1'b0;
  logic [PosWidth-1:0]        position;
  logic [7:0]                 segments;
  logic                       last;

  reading_item_t reading_q[$];
  scan_beat_t    scan_expect_q[$];
  scan_beat_t    want_beat;

  int unsigned frames_sent = 0;
  int unsigned frames_done = 0;
  int unsigned gap_left = 0;
  int unsigned send_calm = 0;
  int unsigned stall_left = 0;
  int unsigned recv_calm = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;

  signed_decimal_seven_segment_scan_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .scan_valid  (scan_valid),
    .scan_stall  (scan_stall),
    .position    (position),
    .segments    (segments),
    .last        (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short idles, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Expands one reading into the eight beats of its scan frame.
  task automatic predict_frame(input logic signed [MagWidth-1:0] reading);
    logic              negative;
    logic [MagWidth:0] magnitude;
    logic [7:0]        seg [ScanLen];
    scan_beat_t        beat;
    int                k;
    negative  = reading[MagWidth-1];
    magnitude = negative ? (17'h10000 - {1'b0, reading}) : {1'b0, reading};
    for (k = 0; k < ScanLen; k++) seg[k] = SegBlank;
    seg[PosSign]     = negative ? SegMinus : SegBlank;
    seg[PosHundreds] = DigitSegs[(magnitude / 100) % 10];
    seg[PosTens]     = DigitSegs[(magnitude / 10) % 10] | SegPoint;
    seg[PosUnits]    = DigitSegs[magnitude % 10];
    for (k = 0; k < ScanLen; k++) begin
      beat.position = k[PosWidth-1:0];
      beat.segments = seg[k];
      beat.last     = (k[PosWidth-1:0] == PosLast);
      scan_expect_q.push_back(beat);
    end
  endtask

  task automatic add_reading(input int v, input bit drain);
    reading_item_t item;
    item.reading = v[MagWidth-1:0];
    item.drain   = drain;
    reading_q.push_back(item);
  endtask

  // Driver: presents queued readings; a drain item waits until every
  // frame already sent has been played out completely.
  always @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
      gap_left    <= 0;
    end else begin
      if (value_valid && !value_stall) begin
        predict_frame(value);
        frames_sent <= frames_sent + 1;
      end
      if (!value_valid || !value_stall) begin
        if (gap_left != 0) begin
          gap_left    <= gap_left - 1;
          value_valid <= 1'b0;
        end else if (reading_q.size() != 0 &&
                     !(reading_q[0].drain &&
                       (value_valid || frames_sent != frames_done))) begin
          value_valid <= 1'b1;
          value       <= reading_q[0].reading;
          void'(reading_q.pop_front());
          if (send_calm != 0) begin
            send_calm <= send_calm - 1;
            gap_left  <= 0;
          end else begin
            gap_left <= idle_len();
            if ($urandom_range(0, 29) == 0) send_calm <= 40;
          end
        end else begin
          value_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted scan beat and drives a random stall.
  always @(posedge clk) begin
    if (rst) begin
      scan_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (scan_valid && !scan_stall) begin
        if (scan_expect_q.size() == 0) begin
          $error("scan beat with nothing expected: position %0d segments %02h last %0b",
                 position, segments, last);
          errors++;
        end else begin
          want_beat = scan_expect_q.pop_front();
          if (position !== want_beat.position) begin
            $error("position: expected %0d, got %0d", want_beat.position, position);
            errors++;
          end
          if (segments !== want_beat.segments) begin
            $error("segments: expected %02h, got %02h", want_beat.segments, segments);
            errors++;
          end
          if (last !== want_beat.last) begin
            $error("last: expected %0b, got %0b", want_beat.last, last);
            errors++;
          end
        end
        if (last === 1'b1) frames_done <= frames_done + 1;
      end
      if (stall_left != 0) begin
        scan_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        scan_stall <= 1'b0;
        if (recv_calm != 0) begin
          recv_calm <= recv_calm - 1;
        end else if ($urandom_range(0, 3) == 0) begin
          stall_left <= idle_len();
          if ($urandom_range(0, 19) == 0) recv_calm <= 60;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int directed [];
    int v;
    int base;
    int i;
    directed = {0, 1, -1, 9, 10, 99, 100, -100, 999, -999, 1000, 1234, -1234,
                5678, 12345, -10, 255, 256, 21845, -21846, 32767, -32768,
                -32767, 30000};
    foreach (directed[n]) add_reading(directed[n], 1'b0);
    for (i = 0; i < 200; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: v = $urandom_range(0, 65535);
        5, 6, 7:       v = int'($urandom_range(0, 1998)) - 999;
        default: begin
          base = (10 ** $urandom_range(1, 4)) * $urandom_range(1, 9);
          v = base + int'($urandom_range(0, 2)) - 1;
          if ($urandom_range(0, 1) == 1) v = -v;
        end
      endcase
      // Let the pipe run dry before the random part and again half-way.
      add_reading(v, (i == 0) || (i == 100));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Sampled away from the rising edge so the driver's updates have settled.
    while (reading_q.size() != 0 || value_valid) @(negedge clk);
    while (scan_expect_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && scan_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
